@@ hdl/amps_pkg.sv @@
// Package for the periodic-saturation affine multiply-accumulate block.
// Holds transaction structs, register index codes and accumulator constants.
// No dependencies; every other file imports it.
package amps_pkg;

	localparam int LANES = 8;
	localparam int GROUP_SIZE = 16;
	localparam int ELEM_W = $clog2(GROUP_SIZE);
	localparam int VCOUNT_W = 4;
	localparam int INTERVAL_W = 13;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int PROD_W = 24;
	// Sums stay below 2^41 in magnitude because a clamp comes at least every
	// 8191 groups; 48 bits leave margin.
	localparam int ACC_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_INTERVAL = 1'd1;

	localparam logic signed [ACC_W-1:0] ACC_I32_MAX = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
	localparam logic signed [ACC_W-1:0] ACC_I32_MIN = {{(ACC_W-32){1'b1}}, 32'h80000000};

	typedef struct packed {
		logic               row_first;
		logic signed [31:0] row_bias;
		logic signed [15:0] weight;
		logic signed [7:0]  in_lane0;
		logic signed [7:0]  in_lane1;
		logic signed [7:0]  in_lane2;
		logic signed [7:0]  in_lane3;
		logic signed [7:0]  in_lane4;
		logic signed [7:0]  in_lane5;
		logic signed [7:0]  in_lane6;
		logic signed [7:0]  in_lane7;
		logic               row_last;
	} amps_in_t;

	typedef struct packed {
		logic signed [31:0] out_lane0;
		logic signed [31:0] out_lane1;
		logic signed [31:0] out_lane2;
		logic signed [31:0] out_lane3;
		logic signed [31:0] out_lane4;
		logic signed [31:0] out_lane5;
		logic signed [31:0] out_lane6;
		logic signed [31:0] out_lane7;
		logic [31:0]        saturation_total;
	} amps_out_t;

	// Per-cycle accumulate command from the group sequencer to the lanes.
	typedef struct packed {
		logic step;
		logic first;
		logic clamp;
	} amps_step_t;

endpackage

@@ hdl/affine_mac_periodic_saturation.sv @@
// A transaction accepted into the input register moves to the product register and is then
// summed into the accumulator and the result register, which load in the same cycle.
// Throughput: one item per cycle unless held; the accumulator loop has one register.
// The whole pipe holds only while a result waits and out_ready is low.
// Reset clears accumulators, counters, clamp count and valid flags; config returns
// to one lane and an interval of one group.
module affine_mac_periodic_saturation
	import amps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  amps_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output amps_out_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [VCOUNT_W-1:0]   vcount_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  advance;
	logic                  valid_s1;
	amps_in_t              in_s1;
	logic                  valid_s2;
	logic                  first_s2;
	logic                  last_s2;
	logic signed [31:0]    bias_s2;
	logic                  step;
	amps_step_t            cmd;
	logic [VCOUNT_W-1:0]   lanes;
	logic [LANES-1:0]      active;
	logic signed [7:0]     lane_x [LANES];
	logic signed [31:0]    lane_sum [LANES];
	logic signed [31:0]    lane_out [LANES];
	logic [LANES-1:0]      lane_evt;
	logic [31:0]           clamp_cnt_q;
	logic [31:0]           clamp_cnt_next;
	logic                  res_valid_q;
	amps_out_t             res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= VCOUNT_W'(1);
			interval_q <= INTERVAL_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VECTOR_COUNT: vcount_q <= cfg_data[VCOUNT_W-1:0];
				REG_SAT_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipe moves unless a finished result is still waiting.
	assign advance  = !res_valid_q || out_ready;
	assign in_ready = advance;
	assign step     = advance && valid_s2;

	// Input and control pipeline registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			in_s1    <= in_data;
			first_s2 <= in_s1.row_first;
			last_s2  <= in_s1.row_last;
			bias_s2  <= in_s1.row_bias;
		end
	end

	// Active lanes follow the vector count, limited to the lane count.
	assign lanes = (vcount_q > VCOUNT_W'(LANES)) ? VCOUNT_W'(LANES) : vcount_q;

	always_comb begin
		for (int n = 0; n < LANES; n++) begin
			active[n] = (VCOUNT_W'(n) < lanes);
		end
	end

	assign lane_x[0] = in_s1.in_lane0;
	assign lane_x[1] = in_s1.in_lane1;
	assign lane_x[2] = in_s1.in_lane2;
	assign lane_x[3] = in_s1.in_lane3;
	assign lane_x[4] = in_s1.in_lane4;
	assign lane_x[5] = in_s1.in_lane5;
	assign lane_x[6] = in_s1.in_lane6;
	assign lane_x[7] = in_s1.in_lane7;

	amps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.first    (first_s2),
		.last     (last_s2),
		.interval (interval_q),
		.cmd      (cmd)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		amps_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (advance),
			.weight    (in_s1.weight),
			.x         (lane_x[g]),
			.bias      (bias_s2),
			.active    (active[g]),
			.cmd       (cmd),
			.sum_sat   (lane_sum[g]),
			.clamp_evt (lane_evt[g])
		);
		assign lane_out[g] = active[g] ? lane_sum[g] : 32'sd0;
	end

	// Running count of clamp events over all lanes.
	assign clamp_cnt_next = clamp_cnt_q + 32'($countones(lane_evt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_cnt_q <= '0;
		end else if (step) begin
			clamp_cnt_q <= clamp_cnt_next;
		end
	end

	// Result register, loaded on the last element of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s2) begin
			res_q.out_lane0        <= lane_out[0];
			res_q.out_lane1        <= lane_out[1];
			res_q.out_lane2        <= lane_out[2];
			res_q.out_lane3        <= lane_out[3];
			res_q.out_lane4        <= lane_out[4];
			res_q.out_lane5        <= lane_out[5];
			res_q.out_lane6        <= lane_out[6];
			res_q.out_lane7        <= lane_out[7];
			res_q.saturation_total <= clamp_cnt_next;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule

@@ hdl/amps_ctrl.sv @@
// Group sequencer: counts elements per group and groups since the last clamp.
// Issues the accumulate command to the lanes. Depends on amps_pkg.
module amps_ctrl
	import amps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  first,
	input  logic                  last,
	input  logic [INTERVAL_W-1:0] interval,
	output amps_step_t            cmd
);

	logic [ELEM_W-1:0]     elem_q;
	logic [INTERVAL_W-1:0] groups_q;
	logic [ELEM_W-1:0]     elem_base;
	logic [INTERVAL_W-1:0] groups_base;
	logic [INTERVAL_W:0]   groups_inc;
	logic [INTERVAL_W-1:0] interval_eff;
	logic                  group_end;
	logic                  interval_hit;
	logic [ELEM_W-1:0]     elem_next;
	logic [INTERVAL_W-1:0] groups_next;

	// An interval of zero acts as one group.
	assign interval_eff = (interval == '0) ? INTERVAL_W'(1) : interval;

	// A new row restarts both counters before this element is counted.
	always_comb begin
		elem_base    = first ? '0 : elem_q;
		groups_base  = first ? '0 : groups_q;
		group_end    = (elem_base == ELEM_W'(GROUP_SIZE - 1));
		groups_inc   = {1'b0, groups_base} + (INTERVAL_W+1)'(1);
		interval_hit = group_end && (groups_inc >= {1'b0, interval_eff});
		elem_next    = elem_base + ELEM_W'(1);
		groups_next  = groups_base;
		if (group_end) begin
			groups_next = interval_hit ? '0 : groups_inc[INTERVAL_W-1:0];
		end
		if (last) begin
			elem_next   = '0;
			groups_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q   <= '0;
			groups_q <= '0;
		end else if (step) begin
			elem_q   <= elem_next;
			groups_q <= groups_next;
		end
	end

	// The end-of-row clamp and an interval clamp in the same element act once.
	assign cmd.step  = step;
	assign cmd.first = first;
	assign cmd.clamp = interval_hit || last;

endmodule

@@ hdl/amps_lane.sv @@
// One lane: registered weight times input product, then the accumulator with
// bias load and clamp to the signed 32-bit range. Depends on amps_pkg.
module amps_lane
	import amps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic signed [15:0] weight,
	input  logic signed [7:0]  x,
	input  logic signed [31:0] bias,
	input  logic               active,
	input  amps_step_t         cmd,
	output logic signed [31:0] sum_sat,
	output logic               clamp_evt
);

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  sat;
	logic                     over_hi;
	logic                     over_lo;

	// Product stage.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= weight * x;
		end
	end

	// Accumulate, then clamp when the sequencer asks for it.
	always_comb begin
		base    = cmd.first ? {{(ACC_W-32){bias[31]}}, bias} : acc_q;
		sum     = base + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		over_hi = (sum > ACC_I32_MAX);
		over_lo = (sum < ACC_I32_MIN);
		if (over_hi) begin
			sat = ACC_I32_MAX;
		end else if (over_lo) begin
			sat = ACC_I32_MIN;
		end else begin
			sat = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.step && active) begin
			acc_q <= cmd.clamp ? sat : sum;
		end
	end

	assign sum_sat   = sat[31:0];
	assign clamp_evt = cmd.step && active && cmd.clamp && (over_hi || over_lo);

endmodule

@@ dv/affine_mac_periodic_saturation_tb.sv @@
// Self-checking testbench for affine_mac_periodic_saturation: directed rows, then random rows
// under several register settings and handshake idling patterns.
// Depends on amps_pkg and the block's RTL only.
module affine_mac_periodic_saturation_tb
	import amps_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int RANDOM_PHASES = 12;
	localparam longint SUM_MAX = 2147483647;
	localparam longint SUM_MIN = -longint'(2147483647) - 1;

	typedef struct {
		amps_in_t item;
		bit       drain_first;
	} queued_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	amps_in_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	amps_out_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Items waiting to be sent and row sums waiting to come out.
	queued_item_t item_stream [$];
	amps_out_t    row_results [$];
	queued_item_t next_item;
	amps_out_t    oldest_row;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          error_count = 0;

	// Mirror of the block's registers and accumulation state.
	logic [VCOUNT_W-1:0]   model_vec_count = VCOUNT_W'(1);
	logic [INTERVAL_W-1:0] model_interval = INTERVAL_W'(1);
	longint                lane_sum [LANES];
	int unsigned           elems_in_group = 0;
	int unsigned           groups_done = 0;
	logic [31:0]           clamp_total = '0;

	affine_mac_periodic_saturation dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic signed [7:0] in_lane(amps_in_t it, int n);
		case (n)
			0: return it.in_lane0;
			1: return it.in_lane1;
			2: return it.in_lane2;
			3: return it.in_lane3;
			4: return it.in_lane4;
			5: return it.in_lane5;
			6: return it.in_lane6;
			default: return it.in_lane7;
		endcase
	endfunction

	function automatic logic [31:0] out_lane(amps_out_t r, int n);
		case (n)
			0: return r.out_lane0;
			1: return r.out_lane1;
			2: return r.out_lane2;
			3: return r.out_lane3;
			4: return r.out_lane4;
			5: return r.out_lane5;
			6: return r.out_lane6;
			default: return r.out_lane7;
		endcase
	endfunction

	// Lane n of the packed lane word goes to in_lane<n>.
	function automatic amps_in_t make_item(bit first, bit last, logic [31:0] bias,
			logic [15:0] w, logic [63:0] lanes);
		amps_in_t it;
		it.row_first = first;
		it.row_bias = bias;
		it.weight = w;
		it.in_lane0 = lanes[7:0];
		it.in_lane1 = lanes[15:8];
		it.in_lane2 = lanes[23:16];
		it.in_lane3 = lanes[31:24];
		it.in_lane4 = lanes[39:32];
		it.in_lane5 = lanes[47:40];
		it.in_lane6 = lanes[55:48];
		it.in_lane7 = lanes[63:56];
		it.row_last = last;
		return it;
	endfunction

	function automatic void clamp_active_lanes(int lanes);
		for (int n = 0; n < lanes; n++) begin
			if (lane_sum[n] > SUM_MAX) begin
				lane_sum[n] = SUM_MAX;
				clamp_total++;
			end else if (lane_sum[n] < SUM_MIN) begin
				lane_sum[n] = SUM_MIN;
				clamp_total++;
			end
		end
	endfunction

	// Applies one accepted element to the lane sums and queues the row result on row_last.
	function automatic void advance_row_sums(amps_in_t it);
		int          lanes;
		int unsigned interval;
		logic [31:0] word [LANES];
		amps_out_t   row;
		lanes = (model_vec_count > LANES) ? LANES : int'(model_vec_count);
		interval = (model_interval == 0) ? 1 : model_interval;
		if (it.row_first) begin
			for (int n = 0; n < lanes; n++)
				lane_sum[n] = longint'($signed(it.row_bias));
			elems_in_group = 0;
			groups_done = 0;
		end
		for (int n = 0; n < lanes; n++)
			lane_sum[n] += longint'($signed(it.weight)) * longint'($signed(in_lane(it, n)));
		// A full group may trigger the periodic clamp.
		elems_in_group++;
		if (elems_in_group >= GROUP_SIZE) begin
			elems_in_group = 0;
			groups_done++;
			if (groups_done >= interval) begin
				clamp_active_lanes(lanes);
				groups_done = 0;
			end
		end
		if (!it.row_last)
			return;
		clamp_active_lanes(lanes);
		elems_in_group = 0;
		groups_done = 0;
		for (int n = 0; n < LANES; n++)
			word[n] = (n < lanes) ? lane_sum[n][31:0] : 32'd0;
		row.out_lane0 = word[0];
		row.out_lane1 = word[1];
		row.out_lane2 = word[2];
		row.out_lane3 = word[3];
		row.out_lane4 = word[4];
		row.out_lane5 = word[5];
		row.out_lane6 = word[6];
		row.out_lane7 = word[7];
		row.saturation_total = clamp_total;
		row_results.push_back(row);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			error_count++;
		end
	endfunction

	// Input driver: presents queued items, idles at random, holds back a marked item until
	// every outstanding row result has arrived.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				advance_row_sums(in_data);
			if (!in_valid || in_ready) begin
				if (item_stream.size() != 0
						&& !(item_stream[0].drain_first && row_results.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					next_item = item_stream.pop_front();
					in_valid <= 1'b1;
					in_data <= next_item.item;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compares each result transaction with the oldest predicted row.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (row_results.size() == 0) begin
					$error("result transaction with no row outstanding");
					error_count++;
				end else begin
					oldest_row = row_results.pop_front();
					for (int n = 0; n < LANES; n++)
						check_field($sformatf("out_lane%0d", n), out_lane(oldest_row, n),
							out_lane(out_data, n));
					check_field("saturation_total", oldest_row.saturation_total,
						out_data.saturation_total);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (item_stream.size() != 0 || in_valid || row_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_VECTOR_COUNT)
			model_vec_count = value[VCOUNT_W-1:0];
		else
			model_interval = value[INTERVAL_W-1:0];
	endtask

	task automatic set_registers(int unsigned vcount, int unsigned interval);
		write_reg(REG_VECTOR_COUNT, CFG_W'(vcount));
		write_reg(REG_SAT_INTERVAL, CFG_W'(interval));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queues mostly well-formed rows with random content. The first row of a phase carries
	// on the row left open by the previous phase; some rows lack row_first and a few items
	// are pure noise. The last row is cut short wherever the budget runs out.
	task automatic queue_random_rows(int unsigned budget);
		int unsigned made;
		int unsigned len;
		int unsigned kind;
		int unsigned push;
		bit          steer;
		bit          drained;
		bit          first;
		bit          last;
		logic [31:0] bias;
		logic [15:0] w;
		logic [63:0] lanes;
		made = 0;
		drained = 0;
		while (made < budget) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(41, 72) : $urandom_range(1, 40);
			kind = (made == 0) ? 0 : $urandom_range(9);
			push = $urandom_range(2);
			case ($urandom_range(3))
				0: bias = $urandom();
				1: bias = 32'h7fffffff - $urandom_range(0, 1 << 24);
				2: bias = 32'h80000000 + $urandom_range(0, 1 << 24);
				default: bias = 32'($urandom_range(0, 511)) - 32'd256;
			endcase
			for (int k = 0; k < len && made < budget; k++) begin
				steer = (push != 0) && ($urandom_range(3) != 0);
				case ($urandom_range(3))
					0: w = 16'($urandom());
					1: w = $urandom_range(1) ? 16'h7fff : 16'h8000;
					2: w = 16'($urandom_range(0, 15)) - 16'd8;
					default: w = 16'($urandom_range(16384, 32767));
				endcase
				if (steer)
					w = 16'($urandom_range(16384, 32767));
				for (int n = 0; n < LANES; n++) begin
					if (steer && push == 1)
						lanes[8*n +: 8] = 8'($urandom_range(64, 127));
					else if (steer)
						lanes[8*n +: 8] = 8'($urandom_range(128, 192));
					else if ($urandom_range(7) == 0)
						lanes[8*n +: 8] = $urandom_range(1) ? 8'h7f : 8'h80;
					else
						lanes[8*n +: 8] = 8'($urandom());
				end
				if (kind == 1) begin
					first = 1'($urandom_range(1));
					last = ($urandom_range(3) == 0);
				end else begin
					first = (k == 0) && (kind != 0);
					last = (k == len - 1);
				end
				item_stream.push_back('{make_item(first, last, bias, w, lanes),
					!drained && k == 0 && made >= budget / 2});
				if (!drained && k == 0 && made >= budget / 2)
					drained = 1;
				made++;
			end
		end
	endtask

	initial begin
		int unsigned vcount;
		int unsigned interval;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// All lanes, clamp after every group: extreme values, both clamp directions, and a
		// row whose first group clamps high before the partial group at its end pulls it back.
		set_registers(8, 1);
		@(negedge clk);
		item_stream.push_back('{make_item(1'b1, 1'b1, 32'h7fffffff, 16'h7fff, {8{8'h7f}}),
			1'b0});
		item_stream.push_back('{make_item(1'b1, 1'b1, 32'h80000000, 16'h7fff, {8{8'h80}}),
			1'b0});
		item_stream.push_back('{make_item(1'b1, 1'b1, 32'h0, 16'h8000, {4{8'h80, 8'h7f}}),
			1'b0});
		for (int k = 0; k < 18; k++)
			item_stream.push_back('{make_item(k == 0, k == 17, 32'h7fff0000,
				(k < 16) ? 16'h7fff : 16'h8000, {8{8'h7f}}), 1'b0});
		wait_drained();

		// No active lane and an interval of zero: every lane reads zero.
		set_registers(0, 0);
		@(negedge clk);
		item_stream.push_back('{make_item(1'b1, 1'b1, 32'h12345678, 16'h1234,
			64'h0123456789abcdef), 1'b0});
		wait_drained();

		// Lane count above the maximum, longest interval, rows carried on without row_first.
		set_registers(15, 8191);
		@(negedge clk);
		item_stream.push_back('{make_item(1'b0, 1'b0, 32'hdeadbeef, 16'h0001, {8{8'h01}}),
			1'b0});
		item_stream.push_back('{make_item(1'b0, 1'b1, 32'h0, 16'hffff, {8{8'h80}}), 1'b0});
		item_stream.push_back('{make_item(1'b1, 1'b1, 32'h0, 16'h0000, 64'h0), 1'b0});
		wait_drained();

		// Random phases: each picks a register setting and an idling pattern.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin vcount = 8; interval = 1; end
				1: begin vcount = 3; interval = 0; end
				2: begin vcount = 15; interval = 2; end
				3: begin vcount = 0; interval = 8191; end
				4: begin vcount = 5; interval = 4096; end
				5: begin vcount = 1; interval = 1; end
				default: begin
					vcount = $urandom_range(1, 8);
					interval = $urandom_range(1, 4);
				end
			endcase
			set_registers(vcount, interval);
			@(negedge clk);
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 67; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 67; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			queue_random_rows(PHASE_ITEMS);
			wait_drained();
		end

		if (error_count == 0)
			$display("affine_mac_periodic_saturation_tb: done, clean");
		else
			$display("affine_mac_periodic_saturation_tb: done, errors");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("affine_mac_periodic_saturation_tb: done, errors");
		$finish;
	end

endmodule
